FILE: rtl/core/mcsc_pkg.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller package
// Shared types, codes and register reset values.
// ----------------------------------------------------------------------------
package mcsc_pkg;

  localparam int unsigned NSLOTS   = 10;
  localparam int unsigned CFG_IDXW = 3;
  localparam int unsigned CFG_DW   = 16;

  typedef enum logic [3:0] {
    ACT_MS_TICK  = 4'd0,
    ACT_TIMER    = 4'd1,
    ACT_EXT      = 4'd2,
    ACT_MIDI_CLK = 4'd3,
    ACT_MIDI_POS = 4'd4,
    ACT_START    = 4'd5,
    ACT_CONT     = 4'd6,
    ACT_STOP     = 4'd7,
    ACT_RESET    = 4'd8
  } action_e;

  typedef enum logic [3:0] {
    EV_STATUS     = 4'd0,
    EV_MIDI_TICK  = 4'd1,
    EV_START      = 4'd2,
    EV_CONTINUE   = 4'd3,
    EV_STOP       = 4'd4,
    EV_POS_ZERO   = 4'd5,
    EV_CLK_ADV    = 4'd6,
    EV_CLK_RESET  = 4'd7,
    EV_KILL_NOTE  = 4'd8,
    EV_SONG_RESET = 4'd9,
    EV_RELOAD     = 4'd10
  } event_e;

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_TEMPO_SCALE   = 3'd0,
    CFG_SLOW_THRESH   = 3'd1,
    CFG_HOLDOFF       = 3'd2,
    CFG_LED_ON        = 3'd3,
    CFG_NOTE_KILL     = 3'd4,
    CFG_NOTE_STOP     = 3'd5,
    CFG_MIDI_OVERRIDE = 3'd6
  } cfg_idx_e;

  localparam logic [8:0]  RST_TEMPO_SCALE   = 9'd245;
  localparam logic [7:0]  RST_SLOW_THRESH   = 8'd2;
  localparam logic [7:0]  RST_HOLDOFF       = 8'd10;
  localparam logic [7:0]  RST_LED_ON        = 8'd10;
  localparam logic [15:0] RST_NOTE_KILL     = 16'd10000;
  localparam logic [15:0] RST_NOTE_STOP     = 16'd50;
  localparam logic [15:0] RST_MIDI_OVERRIDE = 16'd976;
  localparam logic [15:0] RST_TIMER_IVL     = 16'd255;

  typedef struct packed {
    logic [3:0] action;
    logic       internal_selected;
    logic [7:0] pot_value;
    logic       reset_request;
    logic [7:0] song_position;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [15:0] event_value;
    logic        led_lit;
    logic        internal_mode;
    logic        playing;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  tempo_scale;
    logic [7:0]  slow_pot_threshold;
    logic [7:0]  pulse_holdoff_ticks;
    logic [7:0]  led_on_ticks;
    logic [15:0] note_kill_ticks;
    logic [15:0] note_stop_ticks;
    logic [15:0] midi_override_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] value;
  } slot_t;

  typedef struct packed {
    logic                     load;
    logic [NSLOTS-1:0]        mask;
    slot_t [NSLOTS-1:0]       slots;
    logic                     led_lit;
    logic                     internal_mode;
    logic                     playing;
  } core_ctl_t;

endpackage

FILE: rtl/core/mcsc_if.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mcsc_in_if import mcsc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mcsc_out_if import mcsc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/mcsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller configuration registers
// Write-only register file for scale, thresholds and delays.
// ----------------------------------------------------------------------------
module mcsc_cfg_regs import mcsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tempo_scale         <= RST_TEMPO_SCALE;
      cfg_q.slow_pot_threshold  <= RST_SLOW_THRESH;
      cfg_q.pulse_holdoff_ticks <= RST_HOLDOFF;
      cfg_q.led_on_ticks        <= RST_LED_ON;
      cfg_q.note_kill_ticks     <= RST_NOTE_KILL;
      cfg_q.note_stop_ticks     <= RST_NOTE_STOP;
      cfg_q.midi_override_ticks <= RST_MIDI_OVERRIDE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMPO_SCALE:   cfg_q.tempo_scale         <= cfg_data_i[8:0];
        CFG_SLOW_THRESH:   cfg_q.slow_pot_threshold  <= cfg_data_i[7:0];
        CFG_HOLDOFF:       cfg_q.pulse_holdoff_ticks <= cfg_data_i[7:0];
        CFG_LED_ON:        cfg_q.led_on_ticks        <= cfg_data_i[7:0];
        CFG_NOTE_KILL:     cfg_q.note_kill_ticks     <= cfg_data_i;
        CFG_NOTE_STOP:     cfg_q.note_stop_ticks     <= cfg_data_i;
        CFG_MIDI_OVERRIDE: cfg_q.midi_override_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/mcsc_core.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller core
// Input register, controller state and per-item result slot generation.
// ----------------------------------------------------------------------------
module mcsc_core import mcsc_pkg::*; #(
  parameter int unsigned TICKS_PER_BEAT = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  mcsc_in_if.sink    in_ch,
  input  logic       buf_free_i,
  output core_ctl_t  ctl_o
);

  localparam int unsigned TW = (TICKS_PER_BEAT > 1) ? $clog2(TICKS_PER_BEAT) : 1;

  function automatic logic [256*TW-1:0] pos_table();
    logic [256*TW-1:0] tbl;
    int unsigned       r;
    tbl = '0;
    r   = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i*TW +: TW] = TW'(r);
      r = ((r + 1) >= TICKS_PER_BEAT) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam logic [256*TW-1:0] POS_TBL = pos_table();

  function automatic logic [TW-1:0] next_tick(input logic [TW-1:0] t);
    logic [TW:0] inc;
    inc = {1'b0, t} + 1'b1;
    return (inc >= (TW+1)'(TICKS_PER_BEAT)) ? '0 : inc[TW-1:0];
  endfunction

  in_item_t    in_q;
  logic        in_vld_q;
  logic        process;

  logic        ia_q, ia_d;
  logic [7:0]  pot_q, pot_d;
  logic [15:0] ivl_q, ivl_d;
  logic [TW-1:0] src_q, src_d;
  logic [TW-1:0] midi_q, midi_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] note_q, note_d;
  logic [15:0] ovr_q, ovr_d;
  logic [7:0]  ledc_q, ledc_d;
  logic        leds_q, leds_d;
  logic        rh_q, rh_d;
  logic        slow_q, slow_d;
  logic        run_q, run_d;

  logic [15:0] product;
  logic [NSLOTS-1:0] mask;
  slot_t [NSLOTS-1:0] slots;

  assign process     = in_vld_q && buf_free_i;
  assign in_ch.ready = !in_vld_q || buf_free_i;
  assign product     = 16'(in_q.pot_value * cfg_i.tempo_scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= in_ch.data;
    end
  end

  always_comb begin
    ia_d   = ia_q;
    pot_d  = pot_q;
    ivl_d  = ivl_q;
    src_d  = src_q;
    midi_d = midi_q;
    hold_d = hold_q;
    note_d = note_q;
    ovr_d  = ovr_q;
    ledc_d = ledc_q;
    leds_d = leds_q;
    rh_d   = rh_q;
    slow_d = slow_q;
    run_d  = run_q;
    mask   = '0;
    for (int s = 0; s < NSLOTS; s++) begin
      slots[s] = '{code: EV_STATUS, value: 16'd0};
    end

    case (action_e'(in_q.action))
      ACT_MS_TICK: begin
        if (hold_q != 8'd0) hold_d = hold_q - 8'd1;
        if (in_q.internal_selected) begin
          if (pot_q != in_q.pot_value || !ia_q) begin
            ivl_d = product;
            pot_d = in_q.pot_value;
            if (in_q.pot_value < cfg_i.slow_pot_threshold) begin
              note_d = cfg_i.note_stop_ticks;
              slow_d = 1'b1;
              if (run_q) begin
                mask[0]       = 1'b1;
                slots[0].code = EV_STOP;
                run_d         = 1'b0;
              end
            end else if (slow_q) begin
              slow_d        = 1'b0;
              mask[0]       = 1'b1;
              slots[0].code = EV_CONTINUE;
              run_d         = 1'b1;
            end
          end
          if (!ia_q) begin
            ia_d           = 1'b1;
            src_d          = '0;
            mask[5:1]      = 5'b11111;
            run_d          = 1'b1;
            slots[5].code  = EV_RELOAD;
            slots[5].value = ivl_d;
          end
        end else if (ia_q) begin
          ia_d      = 1'b0;
          midi_d    = '0;
          src_d     = '0;
          mask[4:1] = 4'b1111;
          run_d     = 1'b1;
        end
        slots[1].code = EV_CLK_RESET;
        slots[2].code = EV_KILL_NOTE;
        slots[3].code = EV_POS_ZERO;
        slots[4].code = EV_START;

        if (note_d != 16'd0) begin
          note_d = note_d - 16'd1;
          if (note_d == 16'd0) mask[6] = 1'b1;
        end
        slots[6].code = EV_KILL_NOTE;

        if (ovr_q != 16'd0) begin
          ovr_d = ovr_q - 16'd1;
          if (ovr_d == 16'd0) begin
            src_d   = '0;
            mask[7] = 1'b1;
            run_d   = 1'b1;
          end
        end
        slots[7].code = EV_START;

        if (!rh_q && in_q.reset_request) begin
          mask[9:8] = 2'b11;
          midi_d    = '0;
          src_d     = '0;
        end
        slots[8].code = EV_SONG_RESET;
        slots[9].code = EV_POS_ZERO;
        rh_d = in_q.reset_request;

        if (ledc_q != 8'd0) begin
          leds_d = 1'b1;
          ledc_d = ledc_q - 8'd1;
        end else begin
          leds_d = 1'b0;
        end
      end
      ACT_TIMER: begin
        if (ia_q && ovr_q == 16'd0 && !slow_q) begin
          mask[1:0]      = 2'b11;
          slots[0].code  = EV_RELOAD;
          slots[0].value = ivl_q;
          slots[1].code  = EV_MIDI_TICK;
          if (run_q) begin
            if (src_q == '0) ledc_d = cfg_i.led_on_ticks;
            mask[2]        = 1'b1;
            slots[2].code  = EV_CLK_ADV;
            slots[2].value = 16'(src_q);
            src_d          = next_tick(src_q);
            note_d         = cfg_i.note_kill_ticks;
          end
        end
      end
      ACT_EXT: begin
        if (!ia_q && ovr_q == 16'd0 && hold_q == 8'd0) begin
          mask[0]       = 1'b1;
          slots[0].code = EV_MIDI_TICK;
          hold_d        = cfg_i.pulse_holdoff_ticks;
          if (run_q) begin
            ledc_d         = cfg_i.led_on_ticks;
            mask[1]        = 1'b1;
            slots[1].code  = EV_CLK_ADV;
            slots[1].value = 16'(src_q);
            src_d          = next_tick(src_q);
            note_d         = cfg_i.note_kill_ticks;
          end
        end
      end
      ACT_MIDI_CLK: begin
        if (!ia_q) begin
          mask[0]       = 1'b1;
          slots[0].code = EV_MIDI_TICK;
          if (run_q) begin
            if (midi_q == '0) ledc_d = cfg_i.led_on_ticks;
            mask[1]        = 1'b1;
            slots[1].code  = EV_CLK_ADV;
            slots[1].value = 16'(midi_q);
            midi_d         = next_tick(midi_q);
            note_d         = cfg_i.note_kill_ticks;
          end
          ovr_d = cfg_i.midi_override_ticks;
        end
      end
      ACT_MIDI_POS: begin
        midi_d = POS_TBL[in_q.song_position*TW +: TW];
      end
      ACT_START: begin
        mask[1:0]     = 2'b11;
        slots[0].code = EV_START;
        slots[1].code = EV_SONG_RESET;
        midi_d        = '0;
        src_d         = '0;
        run_d         = 1'b1;
      end
      ACT_CONT: begin
        run_d         = 1'b1;
        mask[0]       = 1'b1;
        slots[0].code = EV_CONTINUE;
      end
      ACT_STOP: begin
        run_d         = 1'b0;
        mask[0]       = 1'b1;
        slots[0].code = EV_STOP;
        note_d        = cfg_i.note_stop_ticks;
      end
      ACT_RESET: begin
        midi_d = '0;
        src_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ia_q   <= 1'b0;
      pot_q  <= 8'd0;
      ivl_q  <= RST_TIMER_IVL;
      src_q  <= '0;
      midi_q <= '0;
      hold_q <= 8'd0;
      note_q <= 16'd0;
      ovr_q  <= 16'd0;
      ledc_q <= 8'd0;
      leds_q <= 1'b0;
      rh_q   <= 1'b0;
      slow_q <= 1'b0;
      run_q  <= 1'b1;
    end else if (process) begin
      ia_q   <= ia_d;
      pot_q  <= pot_d;
      ivl_q  <= ivl_d;
      src_q  <= src_d;
      midi_q <= midi_d;
      hold_q <= hold_d;
      note_q <= note_d;
      ovr_q  <= ovr_d;
      ledc_q <= ledc_d;
      leds_q <= leds_d;
      rh_q   <= rh_d;
      slow_q <= slow_d;
      run_q  <= run_d;
    end
  end

  assign ctl_o.load          = process;
  assign ctl_o.mask          = mask;
  assign ctl_o.slots         = slots;
  assign ctl_o.led_lit       = leds_d;
  assign ctl_o.internal_mode = ia_d;
  assign ctl_o.playing       = run_d;

endmodule

FILE: rtl/core/mcsc_serializer.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller result serializer
// Holds the result slots of one item and sends them out one per transfer.
// ----------------------------------------------------------------------------
module mcsc_serializer import mcsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctl_t  ctl_i,
  output logic       buf_free_o,
  mcsc_out_if.source out_ch
);

  logic [NSLOTS-1:0]  mask_q, mask_d;
  slot_t [NSLOTS-1:0] slots_q;
  logic               stat_pend_q, stat_pend_d;
  logic               st_led_q, st_int_q, st_play_q;
  out_item_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic               adv;
  logic [NSLOTS-1:0]  pick;

  assign adv        = !out_vld_q || out_ch.ready;
  assign buf_free_o = (mask_q == '0) && (!stat_pend_q || adv);

  always_comb begin
    pick = '0;
    for (int s = NSLOTS - 1; s >= 0; s--) begin
      if (mask_q[s]) pick = NSLOTS'(1) << s;
    end
  end

  always_comb begin
    mask_d      = mask_q;
    stat_pend_d = stat_pend_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    if (adv) begin
      out_d = '0;
      if (mask_q != '0) begin
        mask_d    = mask_q & ~pick;
        out_vld_d = 1'b1;
        for (int s = 0; s < NSLOTS; s++) begin
          if (pick[s]) begin
            out_d.event_res   = slots_q[s].code;
            out_d.event_value = slots_q[s].value;
          end
        end
      end else begin
        out_d.event_res     = EV_STATUS;
        out_d.led_lit       = st_led_q;
        out_d.internal_mode = st_int_q;
        out_d.playing       = st_play_q;
        out_d.last          = 1'b1;
        out_vld_d           = stat_pend_q;
        stat_pend_d         = 1'b0;
      end
    end
    if (ctl_i.load) begin
      mask_d      = ctl_i.mask;
      stat_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      stat_pend_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      stat_pend_q <= stat_pend_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      slots_q   <= ctl_i.slots;
      st_led_q  <= ctl_i.led_lit;
      st_int_q  <= ctl_i.internal_mode;
      st_play_q <= ctl_i.playing;
    end
    out_q <= out_d;
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |-> (mask_q == '0))
    else $error("Result buffer reloaded while slots remain.");

  a_status_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mask_q == '0 && stat_pend_q) |=> (out_vld_q && out_q.last))
    else $error("Status result not issued after the last slot.");

  a_status_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.last) |-> stat_pend_q)
    else $error("Non-final result without a pending status.");

endmodule

FILE: rtl/core/midi_clock_source_controller.sv
// ----------------------------------------------------------------------------
// MIDI clock source controller
// Selects the internal, external or MIDI clock and reports sequencer events.
// ----------------------------------------------------------------------------
// Each transfer on in_ch_i carries one event (ms tick, timer expiry, external
// pulse, MIDI clock, position, start, continue, stop or clock reset). The
// block answers on out_ch_o with up to ten MIDI and sequencer events followed
// by one status result that has last set.
// The first result of an item passes from the input transfer through the
// input register and the result buffer into the output register. Results
// leave at one per cycle while the receiver is ready, so an item gives N
// event results and then one status result; a status-only item streams at
// one per cycle while the receiver is ready. The output register sets this pace.
// The next item is taken into the input register while results still drain,
// and is processed once the buffer has handed its status result over.
// When the receiver stalls, the output register holds its result and the
// input side fills up and then deasserts ready.
// Reset clears all counters and modes, restores the register defaults and
// leaves the song playing in external mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_clock_source_controller import mcsc_pkg::*; #(
  parameter int unsigned TICKS_PER_BEAT = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  mcsc_in_if.sink             in_ch_i,
  mcsc_out_if.source          out_ch_o
);

  cfg_t      cfg;
  core_ctl_t ctl;
  logic      buf_free;

  mcsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcsc_core #(
    .TICKS_PER_BEAT (TICKS_PER_BEAT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_ch      (in_ch_i),
    .buf_free_i (buf_free),
    .ctl_o      (ctl)
  );

  mcsc_serializer u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .buf_free_o (buf_free),
    .out_ch     (out_ch_o)
  );

endmodule
